@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the particle limit checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kpl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kpl: next-cycle check failed");

`endif

@@ design/kpl_pkg.sv @@
// ----------------------------------------------------------------------------
// KLD particle limit package
// Shared widths, register indexes, reset values and sideband type.
// ----------------------------------------------------------------------------
package kpl_pkg;

	localparam int DW = 16;
	localparam int CFG_W = 16;
	localparam int DEN_W = DW + 4;
	localparam int Z_FRAC = 12;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 32;

	localparam logic [CFG_W-1:0] RST_MAX_SAMPLES = 16'd5000;
	localparam logic [CFG_W-1:0] RST_MIN_SAMPLES = 16'd1;
	localparam logic [CFG_W-1:0] RST_QUANTILE_Z = 16'd4055;
	localparam logic [CFG_W-1:0] RST_ERROR_BOUND = 16'd655;

	typedef enum logic [1:0] {
		REG_MAX_SAMPLES = 2'd0,
		REG_MIN_SAMPLES = 2'd1,
		REG_QUANTILE_Z = 2'd2,
		REG_ERROR_BOUND = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic tiny;
		logic [DW-1:0] d;
	} side_t;

endpackage

@@ design/kpl_recip.sv @@
// ----------------------------------------------------------------------------
// Reciprocal divider
// Pipelined restoring division t = 2^(F+1) / (9d), one quotient bit a stage.
// ----------------------------------------------------------------------------
module kpl_recip #(
	parameter int FRAC_BITS = kpl_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  kpl_pkg::side_t             side_in,
	input  logic [kpl_pkg::DEN_W-1:0]  den_in,
	output logic                       vld_out,
	output kpl_pkg::side_t             side_out,
	output logic [FRAC_BITS-1:0]       t_out
);
	import kpl_pkg::*;

	localparam int STEPS = FRAC_BITS + 2;

	logic                 vld_s   [STEPS];
	side_t                side_s  [STEPS];
	logic [DEN_W-1:0]     den_s   [STEPS];
	logic [DEN_W-1:0]     rem_s   [STEPS];
	logic [FRAC_BITS-1:0] q_s     [STEPS];

	logic [DEN_W-1:0]     den_a   [STEPS];
	logic [DEN_W-1:0]     rem_a   [STEPS];
	logic [FRAC_BITS-1:0] q_a     [STEPS];
	logic [DEN_W:0]       trial   [STEPS];
	logic [DEN_W-1:0]     rem_n   [STEPS];
	logic [FRAC_BITS-1:0] q_n     [STEPS];

	always_comb begin
		den_a[0] = den_in;
		rem_a[0] = '0;
		q_a[0] = '0;
		for (int i = 1; i < STEPS; i++) begin
			den_a[i] = den_s[i-1];
			rem_a[i] = rem_s[i-1];
			q_a[i] = q_s[i-1];
		end
		for (int i = 0; i < STEPS; i++) begin
			trial[i] = {rem_a[i], (i == 0)};
			if (trial[i] >= {1'b0, den_a[i]}) begin
				rem_n[i] = DEN_W'(trial[i] - {1'b0, den_a[i]});
				q_n[i] = {q_a[i][FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_n[i] = trial[i][DEN_W-1:0];
				q_n[i] = {q_a[i][FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < STEPS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < STEPS; i++) side_s[i] <= side_s[i-1];
			for (int i = 0; i < STEPS; i++) begin
				den_s[i] <= den_a[i];
				rem_s[i] <= rem_n[i];
				q_s[i] <= q_n[i];
			end
		end
	end

	assign vld_out = vld_s[STEPS-1];
	assign side_out = side_s[STEPS-1];
	assign t_out = q_s[STEPS-1];

endmodule

@@ design/kpl_sqrt.sv @@
// ----------------------------------------------------------------------------
// Square root
// Pipelined digit-by-digit root s = floor(sqrt(t * 2^F)), one bit a stage.
// ----------------------------------------------------------------------------
module kpl_sqrt #(
	parameter int FRAC_BITS = kpl_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  kpl_pkg::side_t       side_in,
	input  logic [FRAC_BITS-1:0] t_in,
	output logic                 vld_out,
	output kpl_pkg::side_t       side_out,
	output logic [FRAC_BITS-1:0] t_out,
	output logic [FRAC_BITS-1:0] s_out
);
	import kpl_pkg::*;

	localparam int STEPS = FRAC_BITS;
	localparam int RW = FRAC_BITS + 2;

	logic                   vld_s  [STEPS];
	side_t                  side_s [STEPS];
	logic [FRAC_BITS-1:0]   t_s    [STEPS];
	logic [FRAC_BITS-1:0]   root_s [STEPS];
	logic [RW-1:0]          rem_s  [STEPS];

	logic [FRAC_BITS-1:0]   t_a    [STEPS];
	logic [FRAC_BITS-1:0]   root_a [STEPS];
	logic [RW-1:0]          rem_a  [STEPS];
	logic [2*FRAC_BITS-1:0] rad    [STEPS];
	logic [RW-1:0]          cand   [STEPS];
	logic [RW-1:0]          trial  [STEPS];
	logic [RW-1:0]          rem_n  [STEPS];
	logic [FRAC_BITS-1:0]   root_n [STEPS];

	always_comb begin
		t_a[0] = t_in;
		root_a[0] = '0;
		rem_a[0] = '0;
		for (int i = 1; i < STEPS; i++) begin
			t_a[i] = t_s[i-1];
			root_a[i] = root_s[i-1];
			rem_a[i] = rem_s[i-1];
		end
		for (int i = 0; i < STEPS; i++) begin
			rad[i] = {t_a[i], {FRAC_BITS{1'b0}}};
			cand[i] = {rem_a[i][FRAC_BITS-1:0], rad[i][2*(STEPS-1-i)+1 -: 2]};
			trial[i] = {root_a[i], 2'b01};
			if (cand[i] >= trial[i]) begin
				rem_n[i] = cand[i] - trial[i];
				root_n[i] = {root_a[i][FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_n[i] = cand[i];
				root_n[i] = {root_a[i][FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < STEPS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < STEPS; i++) side_s[i] <= side_s[i-1];
			for (int i = 0; i < STEPS; i++) begin
				t_s[i] <= t_a[i];
				root_s[i] <= root_n[i];
				rem_s[i] <= rem_n[i];
			end
		end
	end

	assign vld_out = vld_s[STEPS-1];
	assign side_out = side_s[STEPS-1];
	assign t_out = t_s[STEPS-1];
	assign s_out = root_s[STEPS-1];

endmodule

@@ design/kpl_cube.sv @@
// ----------------------------------------------------------------------------
// Cube datapath
// Forms x = 1 - t + sqrt(t)*z, its cube, and the product d * x^3.
// ----------------------------------------------------------------------------
module kpl_cube #(
	parameter int FRAC_BITS = kpl_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  kpl_pkg::side_t              side_in,
	input  logic [FRAC_BITS-1:0]        t_in,
	input  logic [FRAC_BITS-1:0]        s_in,
	input  logic [kpl_pkg::CFG_W-1:0]   quantile_z,
	output logic                        vld_out,
	output kpl_pkg::side_t              side_out,
	output logic [FRAC_BITS+27:0]       num_out
);
	import kpl_pkg::*;

	localparam int PW = FRAC_BITS + CFG_W;
	localparam int XW = FRAC_BITS + 4;
	localparam int H = XW / 2;
	localparam int HH = XW - H;
	localparam int X2W = FRAC_BITS + 8;
	localparam int X3W = FRAC_BITS + 12;
	localparam int NW = X3W + DW;
	localparam logic [XW:0] ONE_X = (XW + 1)'(1) << FRAC_BITS;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	side_t                side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [FRAC_BITS-1:0] t_s1;
	logic [PW-1:0]        p_s1;
	logic [XW-1:0]        x_s2, x_s3, x_s4, x_s5;
	logic [XW+H-1:0]      pa_s3;
	logic [X2W-1:0]       x2_s4, x2_s5;
	logic [X2W+H-1:0]     pb_s5;
	logic [X3W-1:0]       x3_s6;
	logic [NW-1:0]        num_s7;

	logic [XW:0]          xsum;
	logic [2*XW-1:0]      sq;
	logic [X2W+XW-1:0]    cube;

	always_comb begin
		xsum = ONE_X - (XW + 1)'(t_s1) + (XW + 1)'(p_s1[PW-1:Z_FRAC]);
		sq = (2 * XW)'(pa_s3)
			+ ((2 * XW)'((XW + HH)'(x_s3) * (XW + HH)'(x_s3[XW-1:H])) << H);
		cube = (X2W + XW)'(pb_s5)
			+ ((X2W + XW)'((X2W + HH)'(x2_s5) * (X2W + HH)'(x_s5[XW-1:H])) << H);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			t_s1 <= t_in;
			p_s1 <= PW'(s_in) * PW'(quantile_z);
			side_s2 <= side_s1;
			x_s2 <= xsum[XW-1:0];
			side_s3 <= side_s2;
			x_s3 <= x_s2;
			pa_s3 <= (XW + H)'(x_s2) * (XW + H)'(x_s2[H-1:0]);
			side_s4 <= side_s3;
			x_s4 <= x_s3;
			x2_s4 <= sq[2*XW-1:FRAC_BITS];
			side_s5 <= side_s4;
			x_s5 <= x_s4;
			x2_s5 <= x2_s4;
			pb_s5 <= (X2W + H)'(x2_s4) * (X2W + H)'(x_s4[H-1:0]);
			side_s6 <= side_s5;
			x3_s6 <= cube[X2W+XW-1:FRAC_BITS];
			side_s7 <= side_s6;
			num_s7 <= NW'(side_s6.d) * NW'(x3_s6);
		end
	end

	assign vld_out = vld_s7;
	assign side_out = side_s7;
	assign num_out = num_s7;

endmodule

@@ design/kpl_quot.sv @@
// ----------------------------------------------------------------------------
// Ceiling quotient and clamp
// Divides d * x^3 by 2 * epsilon with a ceiling and clamps to the limits; a tiny count gives the upper limit.
// ----------------------------------------------------------------------------
module kpl_quot #(
	parameter int FRAC_BITS = kpl_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  kpl_pkg::side_t             side_in,
	input  logic [FRAC_BITS+27:0]      num_in,
	input  logic [kpl_pkg::CFG_W-1:0]  error_bound,
	input  logic [kpl_pkg::CFG_W-1:0]  lo_limit,
	input  logic [kpl_pkg::CFG_W-1:0]  hi_limit,
	output logic                       vld_out,
	output logic [kpl_pkg::CFG_W-1:0]  result
);
	import kpl_pkg::*;

	localparam int NW = FRAC_BITS + 28;
	localparam int SH = FRAC_BITS - 15;
	localparam int NHW = NW - SH;
	localparam int QW = CFG_W;
	localparam int STEPS = QW;

	logic             vld_s1, tiny_s1, low_s1, big_s1;
	logic [NHW-1:0]   nh_s1;

	logic             vld_s   [STEPS];
	logic             tiny_s  [STEPS];
	logic             low_s   [STEPS];
	logic             big_s   [STEPS];
	logic [QW-1:0]    nhl_s   [STEPS];
	logic [QW-1:0]    rem_s   [STEPS];
	logic [QW-1:0]    q_s     [STEPS];

	logic [QW-1:0]    nhl_a   [STEPS];
	logic [QW-1:0]    rem_a   [STEPS];
	logic [QW-1:0]    q_a     [STEPS];
	logic [QW:0]      trial   [STEPS];
	logic [QW-1:0]    rem_n   [STEPS];
	logic [QW-1:0]    q_n     [STEPS];

	logic             vld_q;
	logic [QW-1:0]    res_q;

	logic [NHW-1:0]   nh_in;
	logic [QW:0]      n_ceil;
	logic [QW:0]      n_low;
	logic [QW-1:0]    n_res;

	always_comb begin
		nh_in = num_in[NW-1:SH];
		nhl_a[0] = nh_s1[QW-1:0];
		rem_a[0] = QW'(nh_s1[NHW-1:QW]);
		q_a[0] = '0;
		for (int i = 1; i < STEPS; i++) begin
			nhl_a[i] = nhl_s[i-1];
			rem_a[i] = rem_s[i-1];
			q_a[i] = q_s[i-1];
		end
		for (int i = 0; i < STEPS; i++) begin
			trial[i] = {rem_a[i], nhl_a[i][QW-1-i]};
			if (trial[i] >= {1'b0, error_bound}) begin
				rem_n[i] = QW'(trial[i] - {1'b0, error_bound});
				q_n[i] = {q_a[i][QW-2:0], 1'b1};
			end else begin
				rem_n[i] = trial[i][QW-1:0];
				q_n[i] = {q_a[i][QW-2:0], 1'b0};
			end
		end

		n_ceil = {1'b0, q_s[STEPS-1]}
			+ (QW + 1)'((rem_s[STEPS-1] != '0) || low_s[STEPS-1]);
		n_low = (n_ceil < {1'b0, lo_limit}) ? {1'b0, lo_limit} : n_ceil;
		if (tiny_s[STEPS-1] || big_s[STEPS-1]) begin
			n_res = hi_limit;
		end else if (n_low > {1'b0, hi_limit}) begin
			n_res = hi_limit;
		end else begin
			n_res = n_low[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < STEPS; i++) vld_s[i] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s[0] <= vld_s1;
			for (int i = 1; i < STEPS; i++) vld_s[i] <= vld_s[i-1];
			vld_q <= vld_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tiny_s1 <= side_in.tiny;
			nh_s1 <= nh_in;
			low_s1 <= |num_in[SH-1:0];
			big_s1 <= nh_in[NHW-1:QW] >= (NHW - QW)'(error_bound);
			tiny_s[0] <= tiny_s1;
			low_s[0] <= low_s1;
			big_s[0] <= big_s1;
			for (int i = 1; i < STEPS; i++) begin
				tiny_s[i] <= tiny_s[i-1];
				low_s[i] <= low_s[i-1];
				big_s[i] <= big_s[i-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				nhl_s[i] <= nhl_a[i];
				rem_s[i] <= rem_n[i];
				q_s[i] <= q_n[i];
			end
			res_q <= n_res;
		end
	end

	assign vld_out = vld_q;
	assign result = res_q;

endmodule

@@ design/kld_particle_count_limit.sv @@
// A bin count runs through the input register, divider, root, cube and quotient pipelines.
// Throughput: one bin count per cycle; every stage holds while the result is stalled.
// The latency is set by the bit-per-stage reciprocal divider, root and quotient pipelines.
// Reset clears the valid bits and loads the registers with 5000, 1, 4055 and 655.
// ----------------------------------------------------------------------------
// KLD particle count limit
// Pipelined KLD-sampling particle limit in the Wilson-Hilferty form.
// ----------------------------------------------------------------------------
module kld_particle_count_limit #(
	parameter int COUNT_WIDTH = kpl_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS = kpl_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [kpl_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       bin_valid,
	output logic                       bin_stall,
	input  logic [kpl_pkg::DW-1:0]     bin_count,
	output logic                       limit_valid,
	input  logic                       limit_stall,
	output logic [kpl_pkg::CFG_W-1:0]  sample_limit
);
	import kpl_pkg::*;

	localparam int KW = (COUNT_WIDTH < DW) ? COUNT_WIDTH : DW;

	logic [CFG_W-1:0]     hi_limit_q, lo_limit_q, quantile_z_q, error_bound_q;
	logic                 en;
	logic [DW-1:0]        k;
	logic                 vld_s1;
	side_t                side_s1;
	logic [DEN_W-1:0]     den_s1;
	side_t                side_in;

	logic                 r_vld, s_vld, c_vld, q_vld;
	side_t                r_side, s_side, c_side;
	logic [FRAC_BITS-1:0] r_t, s_t, s_s;
	logic [FRAC_BITS+27:0] c_num;
	logic [CFG_W-1:0]     q_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_limit_q <= RST_MAX_SAMPLES;
			lo_limit_q <= RST_MIN_SAMPLES;
			quantile_z_q <= RST_QUANTILE_Z;
			error_bound_q <= RST_ERROR_BOUND;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_SAMPLES: hi_limit_q <= cfg_data;
				REG_MIN_SAMPLES: lo_limit_q <= cfg_data;
				REG_QUANTILE_Z: quantile_z_q <= cfg_data;
				REG_ERROR_BOUND: error_bound_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !(limit_valid && limit_stall);
	assign bin_stall = !en;

	always_comb begin
		k = DW'(bin_count[KW-1:0]);
		side_in.tiny = (k[DW-1:1] == '0);
		side_in.d = k - DW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= bin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			den_s1 <= (DEN_W'(side_in.d) << 3) + DEN_W'(side_in.d);
		end
	end

	kpl_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s1), .side_in(side_s1), .den_in(den_s1),
		.vld_out(r_vld), .side_out(r_side), .t_out(r_t)
	);

	kpl_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(r_vld), .side_in(r_side), .t_in(r_t),
		.vld_out(s_vld), .side_out(s_side), .t_out(s_t), .s_out(s_s)
	);

	kpl_cube #(.FRAC_BITS(FRAC_BITS)) u_cube (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(s_vld), .side_in(s_side), .t_in(s_t), .s_in(s_s),
		.quantile_z(quantile_z_q),
		.vld_out(c_vld), .side_out(c_side), .num_out(c_num)
	);

	kpl_quot #(.FRAC_BITS(FRAC_BITS)) u_quot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(c_vld), .side_in(c_side), .num_in(c_num),
		.error_bound(error_bound_q), .lo_limit(lo_limit_q),
		.hi_limit(hi_limit_q),
		.vld_out(q_vld), .result(q_res)
	);

	assign limit_valid = q_vld;
	assign sample_limit = q_res;

endmodule

@@ design/kpl_checker.sv @@
// ----------------------------------------------------------------------------
// Particle limit port checker
// Watches the ports of the particle limit block for handshake and stall slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       bin_stall,
	input logic                       limit_valid,
	input logic                       limit_stall,
	input logic [kpl_pkg::CFG_W-1:0]  sample_limit
);

	`KPL_ASSERT_NEXT(a_out_hold, clk, arst_n, limit_valid && limit_stall, limit_valid)
	`KPL_ASSERT_NEXT(a_out_stable, clk, arst_n, limit_valid && limit_stall, $stable(sample_limit))
	`KPL_ASSERT_SAME(a_stall_passes, clk, arst_n, limit_valid && limit_stall, bin_stall)
	`KPL_ASSERT_SAME(a_stall_cause, clk, arst_n, bin_stall, limit_valid && limit_stall)

endmodule

bind kld_particle_count_limit kpl_checker u_kpl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.bin_stall(bin_stall),
	.limit_valid(limit_valid),
	.limit_stall(limit_stall),
	.sample_limit(sample_limit)
);
